// ===== sv/kldc_pkg.sv =====
// Shared types, codes and constants of the knob lamp dimmer controller.
// No dependencies; the register, sequencer, datapath and top files import this package.
package kldc_pkg;

  // default values of the top level parameters
  localparam int BRIGHT_STEPS_DEF = 100;
  localparam int DUTY_UNIT_A_DEF  = 10;
  localparam int DUTY_UNIT_B_DEF  = 10;

  // fixed field widths
  localparam int CT_W   = 16;
  localparam int DUTY_W = 10;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // knob arithmetic
  localparam int LEVEL_STEP = 5;
  localparam int LEVEL_MIN  = 5;
  localparam int CT_STEP    = 30;

  localparam logic [CT_W-1:0]   RGB_DEN  = 16'd255;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1023;

  // knob operation codes (codes 0 and 3 mean no press)
  localparam logic [1:0] OP_SHORT = 2'd1;
  localparam logic [1:0] OP_LONG  = 2'd2;

  // lamp modes: {panel_type, alt_mode}
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_RGB    = 2'd1;
  localparam logic [1:0] MODE_WC     = 2'd2;
  localparam logic [1:0] MODE_UV     = 2'd3;

  // register indexes
  localparam logic [1:0] REG_PANEL   = 2'd0;
  localparam logic [1:0] REG_RGB     = 2'd1;
  localparam logic [1:0] REG_CT_LOW  = 2'd2;
  localparam logic [1:0] REG_CT_HIGH = 2'd3;

  // register reset values
  localparam logic        PANEL_RST   = 1'b0;
  localparam logic [23:0] RGB_RST     = 24'd100;
  localparam logic [15:0] CT_LOW_RST  = 16'd2700;
  localparam logic [15:0] CT_HIGH_RST = 16'd6500;
  localparam logic [15:0] CT_RST      = 16'd6500;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCALE,
    ST_PLAN,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_t;

  // configuration register contents plus panel write strobe
  typedef struct packed {
    logic        panel_type;
    logic [23:0] rgb_color;
    logic [15:0] ct_low;
    logic [15:0] ct_high;
    logic        panel_wr;
  } cfg_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       in_load;
    logic       update;
    logic       scale;
    logic       plan;
    logic       mul;
    logic       div_step;
    logic       div_store;
    logic       out_load;
    logic [1:0] ch;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       ct_ok;
    logic       out_busy;
  } sts_t;

  // width of unit * level products
  function automatic int prod_width(int steps, int unit_a, int unit_b);
    int m;
    m = (unit_a > unit_b) ? unit_a : unit_b;
    return $clog2(m * steps + 1);
  endfunction

  // clip a duty to the 10-bit PWM range
  function automatic logic [DUTY_W-1:0] sat_duty(logic [15:0] v);
    return (v > 16'(DUTY_MAX)) ? DUTY_MAX : v[DUTY_W-1:0];
  endfunction

endpackage

// ===== sv/kldc_if.sv =====
// Valid/ready channel interfaces: knob events in, duty beats out.
// No dependencies.
interface kldc_knob_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [4:0] knob_delta;

  modport source (output valid, operation, knob_delta, input ready);
  modport sink (input valid, operation, knob_delta, output ready);
endinterface

interface kldc_duty_if;
  logic       valid;
  logic       ready;
  logic [9:0] duty_ch0;
  logic [9:0] duty_ch1;
  logic [9:0] duty_ch2;
  logic [9:0] duty_ch3;
  logic [1:0] mode_now;
  logic       adjust_target;

  modport source (output valid, duty_ch0, duty_ch1, duty_ch2, duty_ch3, mode_now,
                  adjust_target, input ready);
  modport sink (input valid, duty_ch0, duty_ch1, duty_ch2, duty_ch3, mode_now,
                adjust_target, output ready);
endinterface

// ===== sv/kldc_regs.sv =====
// APB-style configuration registers: panel type, RGB colour, CT bounds.
// Depends on kldc_pkg.
module kldc_regs
  import kldc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic        panel_type;
  logic [23:0] rgb_color;
  logic [15:0] ct_low;
  logic [15:0] ct_high;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_type <= PANEL_RST;
      rgb_color  <= RGB_RST;
      ct_low     <= CT_LOW_RST;
      ct_high    <= CT_HIGH_RST;
    end else if (wr) begin
      unique case (idx)
        REG_PANEL:   panel_type <= pwdata[0];
        REG_RGB:     rgb_color  <= pwdata[23:0];
        REG_CT_LOW:  ct_low     <= pwdata[15:0];
        REG_CT_HIGH: ct_high    <= pwdata[15:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_PANEL:   prdata = {31'd0, panel_type};
      REG_RGB:     prdata = {8'd0, rgb_color};
      REG_CT_LOW:  prdata = {16'd0, ct_low};
      REG_CT_HIGH: prdata = {16'd0, ct_high};
    endcase
  end

  assign cfg.panel_type = panel_type;
  assign cfg.rgb_color  = rgb_color;
  assign cfg.ct_low     = ct_low;
  assign cfg.ct_high    = ct_high;
  assign cfg.panel_wr   = wr & (idx == REG_PANEL);

endmodule

// ===== sv/kldc_ctrl.sv =====
// Sequencer: walks one knob event through update, scaling, any divisions, output.
// Depends on kldc_pkg.
module kldc_ctrl
  import kldc_pkg::*;
#(
  parameter int PROD_W = prod_width(BRIGHT_STEPS_DEF, DUTY_UNIT_A_DEF, DUTY_UNIT_B_DEF)
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CNT_W = (PROD_W > 1) ? $clog2(PROD_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       ch;
  logic             more_jobs;

  assign in_ready  = (state == ST_IDLE);
  assign more_jobs = (sts.mode == MODE_RGB) || ((sts.mode == MODE_WC) && sts.ct_ok);

  // state register, step counter, channel index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ch    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MUL) cnt <= '0;
      else if (state == ST_DIV) cnt <= cnt + 1'b1;
      if (state == ST_PLAN) ch <= (sts.mode == MODE_RGB) ? 2'd1 : 2'd0;
      else if (state == ST_STORE) ch <= ch + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_PLAN;
      ST_PLAN:   state_next = more_jobs ? ST_MUL : ST_DONE;
      ST_MUL:    state_next = ST_DIV;
      ST_DIV:    if (cnt == CNT_LAST) state_next = ST_STORE;
      ST_STORE: begin
        if (sts.mode == MODE_RGB && ch != 2'd3) state_next = ST_MUL;
        else state_next = ST_DONE;
      end
      ST_DONE:   if (!sts.out_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd    = '0;
    cmd.ch = ch;
    unique case (state)
      ST_IDLE:   cmd.in_load   = in_valid;
      ST_UPDATE: cmd.update    = 1'b1;
      ST_SCALE:  cmd.scale     = 1'b1;
      ST_PLAN:   cmd.plan      = 1'b1;
      ST_MUL:    cmd.mul       = 1'b1;
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_STORE:  cmd.div_store = 1'b1;
      ST_DONE:   cmd.out_load  = !sts.out_busy;
      default:   cmd           = '0;
    endcase
  end

  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_UPDATE)
    else $error("accepted beat did not start an update");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && cnt == CNT_LAST |=> state == ST_STORE)
    else $error("division ran past its step count");

  a_rgb_ch: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL && sts.mode == MODE_RGB |-> ch != 2'd0)
    else $error("RGB job on channel 0");

endmodule

// ===== sv/kldc_dp.sv =====
// Datapath: mode/level/colour state, products, shared restoring divider,
// duty work registers and the output register. Depends on kldc_pkg.
module kldc_dp
  import kldc_pkg::*;
#(
  parameter int BRIGHT_STEPS = BRIGHT_STEPS_DEF,
  parameter int DUTY_UNIT_A  = DUTY_UNIT_A_DEF,
  parameter int DUTY_UNIT_B  = DUTY_UNIT_B_DEF,
  parameter int PROD_W       = prod_width(BRIGHT_STEPS_DEF, DUTY_UNIT_A_DEF, DUTY_UNIT_B_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [1:0]        operation,
  input  logic signed [4:0] knob_delta,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DUTY_W-1:0] duty_ch0,
  output logic [DUTY_W-1:0] duty_ch1,
  output logic [DUTY_W-1:0] duty_ch2,
  output logic [DUTY_W-1:0] duty_ch3,
  output logic [1:0]        mode_now,
  output logic              adjust_target
);

  localparam int LVL_W = $clog2(BRIGHT_STEPS + 1);
  localparam int SUM_W = LVL_W + 4;
  localparam int CTS_W = CT_W + 2;
  localparam int D_W   = PROD_W + CT_W;

  // event state
  logic                     alt_mode;
  logic                     adjust_sel;
  logic [LVL_W-1:0]         level [4];
  logic [CT_W-1:0]          color_temp;
  logic [1:0]               in_op;
  logic signed [4:0]        in_delta;

  // update path
  logic                     alt_next;
  logic                     adj_next;
  logic [1:0]               mode_next;
  logic [LVL_W-1:0]         lvl_old;
  logic signed [SUM_W-1:0]  lvl_sum;
  logic [LVL_W-1:0]         lvl_new;
  logic signed [CTS_W-1:0]  ct_sum;
  logic [CT_W-1:0]          ct_new;

  // duty path
  logic [1:0]               mode;
  logic [LVL_W-1:0]         lvl_cur;
  logic [PROD_W-1:0]        pa;
  logic [PROD_W-1:0]        pb;
  logic [CT_W-1:0]          t_cl;
  logic [CT_W-1:0]          ct_x;
  logic [CT_W-1:0]          span;
  logic [PROD_W-1:0]        p_sel;
  logic [CT_W-1:0]          fac_sel;
  logic [CT_W-1:0]          den_sel;
  logic [D_W-1:0]           rem;
  logic [D_W-1:0]           dsh;
  logic [CT_W-1:0]          den;
  logic [PROD_W-1:0]        quo;
  logic [PROD_W-1:0]        quo_cmp;
  logic [DUTY_W-1:0]        work [4];

  assign mode    = {cfg.panel_type, alt_mode};
  assign lvl_cur = level[mode];

  // press handling, then rotation on the new mode
  always_comb begin
    alt_next = (in_op == OP_LONG) ? ~alt_mode : alt_mode;
    adj_next = adjust_sel;
    if (in_op == OP_SHORT) adj_next = (cfg.panel_type && alt_mode) ? 1'b0 : ~adjust_sel;
    mode_next = {cfg.panel_type, alt_next};
    lvl_old   = level[mode_next];
  end

  assign lvl_sum = $signed({{(SUM_W-LVL_W){1'b0}}, lvl_old})
                 + SUM_W'(in_delta) * SUM_W'(LEVEL_STEP);
  assign ct_sum  = $signed({2'b00, color_temp}) + CTS_W'(in_delta) * CTS_W'(CT_STEP);

  // brightness clamp to LEVEL_MIN..BRIGHT_STEPS
  always_comb begin
    if (lvl_sum < SUM_W'(LEVEL_MIN)) lvl_new = LVL_W'(LEVEL_MIN);
    else if (lvl_sum > SUM_W'(BRIGHT_STEPS)) lvl_new = LVL_W'(BRIGHT_STEPS);
    else lvl_new = lvl_sum[LVL_W-1:0];
  end

  // colour temperature clamp, low bound tested first
  always_comb begin
    if (ct_sum < $signed({2'b00, cfg.ct_low})) ct_new = cfg.ct_low;
    else if (ct_sum > $signed({2'b00, cfg.ct_high})) ct_new = cfg.ct_high;
    else ct_new = ct_sum[CT_W-1:0];
  end

  // event state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alt_mode   <= 1'b0;
      adjust_sel <= 1'b0;
      color_temp <= CT_RST;
      for (int i = 0; i < 4; i++) level[i] <= LVL_W'(LEVEL_MIN);
    end else begin
      if (cfg.panel_wr) alt_mode <= 1'b0;
      else if (cmd.update) alt_mode <= alt_next;
      if (cmd.update) begin
        adjust_sel <= adj_next;
        if (in_delta != '0) begin
          if (!adj_next) level[mode_next] <= lvl_new;
          else if (mode_next == MODE_WC) color_temp <= ct_new;
        end
      end
    end
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      in_op    <= operation;
      in_delta <= knob_delta;
    end
  end

  // warm-cool split inputs
  always_comb begin
    if (color_temp < cfg.ct_low) t_cl = cfg.ct_low;
    else if (color_temp > cfg.ct_high) t_cl = cfg.ct_high;
    else t_cl = color_temp;
  end
  assign ct_x = t_cl - cfg.ct_low;
  assign span = cfg.ct_high - cfg.ct_low;

  // operand select per channel job
  always_comb begin
    unique case (cmd.ch)
      2'd0: begin p_sel = pa; fac_sel = ct_x;                     den_sel = span;    end
      2'd1: begin p_sel = pa; fac_sel = {8'd0, cfg.rgb_color[23:16]}; den_sel = RGB_DEN; end
      2'd2: begin p_sel = pb; fac_sel = {8'd0, cfg.rgb_color[15:8]};  den_sel = RGB_DEN; end
      2'd3: begin p_sel = pb; fac_sel = {8'd0, cfg.rgb_color[7:0]};   den_sel = RGB_DEN; end
    endcase
  end

  // complement duty of the warm-cool pair: floor(P - q - frac)
  assign quo_cmp = pa - quo - PROD_W'(rem != '0);

  // products, one-bit-per-cycle divider, duty work registers
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      pa <= PROD_W'(DUTY_UNIT_A * lvl_cur);
      pb <= PROD_W'(DUTY_UNIT_B * lvl_cur);
    end
    if (cmd.plan) begin
      work[0] <= (mode == MODE_SINGLE) ? sat_duty(16'(pa)) : '0;
      work[1] <= '0;
      work[2] <= (mode == MODE_UV) ? sat_duty(16'(pb)) : '0;
      work[3] <= '0;
    end
    if (cmd.mul) begin
      rem <= D_W'(p_sel) * D_W'(fac_sel);
      dsh <= D_W'(den_sel) << (PROD_W - 1);
      den <= den_sel;
      quo <= '0;
    end
    if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[PROD_W-2:0], 1'b1};
      end else begin
        quo <= {quo[PROD_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (cmd.div_store) begin
      unique case (cmd.ch)
        2'd0: begin
          work[0] <= sat_duty(16'(quo));
          work[1] <= sat_duty(16'(quo_cmp));
        end
        2'd1: work[1] <= sat_duty(16'(quo));
        2'd2: work[2] <= sat_duty(16'(quo));
        2'd3: work[3] <= sat_duty(16'(quo));
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      duty_ch0      <= work[0];
      duty_ch1      <= work[1];
      duty_ch2      <= work[2];
      duty_ch3      <= work[3];
      mode_now      <= mode;
      adjust_target <= adjust_sel;
    end
  end

  assign sts.mode     = mode;
  assign sts.ct_ok    = cfg.ct_high > cfg.ct_low;
  assign sts.out_busy = out_valid & ~out_ready;

  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    lvl_cur >= LVL_W'(LEVEL_MIN) && lvl_cur <= LVL_W'(BRIGHT_STEPS))
    else $error("brightness level out of range");

  a_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.div_store |-> rem < D_W'(den))
    else $error("divider remainder not below divisor");

  a_panel: assert property (@(posedge clk) disable iff (rst)
    cfg.panel_wr |=> !alt_mode)
    else $error("panel write did not return to primary mode");

endmodule

// ===== sv/knob_lamp_dimmer_controller.sv =====
// Flow: an accepted knob beat passes update, scaling and planning; warm-cool mode (CT
// high above CT low) adds one division and RGB mode three, one per colour, of P quotient
// bits each, P = product width (10 at defaults); the shared restoring divider retires one
// quotient bit per cycle. Beats are taken one at a time, a new one while a result waits.
// Reset: synchronous, active high; registers, mode, levels and colour temperature
// return to their reset values at once, no clearing pass.
module knob_lamp_dimmer_controller
  import kldc_pkg::*;
#(
  parameter int BRIGHT_STEPS = BRIGHT_STEPS_DEF,
  parameter int DUTY_UNIT_A  = DUTY_UNIT_A_DEF,
  parameter int DUTY_UNIT_B  = DUTY_UNIT_B_DEF
) (
  input  logic              clk,
  input  logic              rst,
  kldc_knob_if.sink         knob,
  kldc_duty_if.source       duty,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int PROD_W = prod_width(BRIGHT_STEPS, DUTY_UNIT_A, DUTY_UNIT_B);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  kldc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kldc_ctrl #(
    .PROD_W (PROD_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (knob.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kldc_dp #(
    .BRIGHT_STEPS (BRIGHT_STEPS),
    .DUTY_UNIT_A  (DUTY_UNIT_A),
    .DUTY_UNIT_B  (DUTY_UNIT_B),
    .PROD_W       (PROD_W)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (knob.operation),
    .knob_delta    (knob.knob_delta),
    .out_ready     (duty.ready),
    .out_valid     (duty.valid),
    .duty_ch0      (duty.duty_ch0),
    .duty_ch1      (duty.duty_ch1),
    .duty_ch2      (duty.duty_ch2),
    .duty_ch3      (duty.duty_ch3),
    .mode_now      (duty.mode_now),
    .adjust_target (duty.adjust_target)
  );

  assign knob.ready = in_ready;

endmodule
